>>> rtl/core/wh2d_pkg.sv
// Package for the two-axis weighted histogram: sizes, request and result
// types, register codes, and the saturating adders.
// Depends on nothing; every module of the block imports it.
package wh2d_pkg;

    // Sizes of the histogram.
    localparam int MAX_BINS_X  = 64;
    localparam int MAX_BINS_Y  = 64;
    localparam int WEIGHT_BITS = 48;
    localparam int NBINS       = MAX_BINS_X * MAX_BINS_Y;

    // Field widths.
    localparam int COORD_W   = 16;
    localparam int SCALE_W   = 16;
    localparam int BUCKET_W  = 7;
    localparam int VALUE_W   = 16;
    localparam int SECOND_W  = 56;
    localparam int COUNT_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = COORD_W + SCALE_W;
    localparam int AXIS_W    = PROD_W - FRAC_W;
    localparam int IDX_X_W   = $clog2(MAX_BINS_X);
    localparam int IDX_Y_W   = $clog2(MAX_BINS_Y);
    localparam int LIN_W     = $clog2(NBINS);
    localparam int INDEX_W   = 12;
    localparam int CONTRIB_W = 2 * VALUE_W;
    localparam int MODE_W    = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X        = 3'd0,
        CFG_SCALE_X      = 3'd1,
        CFG_BUCKETS_X    = 3'd2,
        CFG_MIN_Y        = 3'd3,
        CFG_SCALE_Y      = 3'd4,
        CFG_BUCKETS_Y    = 3'd5,
        CFG_ERROR_MODE   = 3'd6,
        CFG_COUNT_ENABLE = 3'd7
    } cfg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE     = 2'd0,
        MODE_SQUARE   = 2'd1,
        MODE_VARIANCE = 2'd2
    } err_mode_t;

    // Operation codes carried in a request.
    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0]  min_x;
        logic [SCALE_W-1:0]  scale_x;
        logic [BUCKET_W-1:0] buckets_x;
        logic [COORD_W-1:0]  min_y;
        logic [SCALE_W-1:0]  scale_y;
        logic [BUCKET_W-1:0] buckets_y;
        logic [MODE_W-1:0]   error_mode;
        logic                count_enable;
    } cfg_t;

    typedef struct packed {
        logic                      op;
        logic [COORD_W-1:0]        coord_x;
        logic [COORD_W-1:0]        coord_y;
        logic signed [VALUE_W-1:0] sample_value;
        logic [VALUE_W-1:0]        sample_variance;
    } req_t;

    typedef struct packed {
        logic                          accepted;
        logic [INDEX_W-1:0]            bin_index;
        logic signed [WEIGHT_BITS-1:0] bin_weight;
        logic [SECOND_W-1:0]           bin_second;
        logic [COUNT_W-1:0]            bin_count;
        logic signed [WEIGHT_BITS-1:0] total_weight;
        logic [SECOND_W-1:0]           total_second;
    } res_t;

    // One bin as held in the bin memory.
    typedef struct packed {
        logic signed [WEIGHT_BITS-1:0] weight;
        logic [SECOND_W-1:0]           second;
        logic [COUNT_W-1:0]            count;
    } bin_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic mul;
        logic addr;
        logic upd;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } dp_stat_t;

    // Signed add of a sample value, clamped to the weight range.
    function automatic logic signed [WEIGHT_BITS-1:0] wadd(
        input logic signed [WEIGHT_BITS-1:0] a,
        input logic signed [VALUE_W-1:0]     v
    );
        logic signed [WEIGHT_BITS:0] s;
        s = $signed({a[WEIGHT_BITS-1], a}) + (WEIGHT_BITS + 1)'(v);
        if (s[WEIGHT_BITS] != s[WEIGHT_BITS-1]) begin
            wadd = s[WEIGHT_BITS] ? {1'b1, {(WEIGHT_BITS - 1){1'b0}}}
                                  : {1'b0, {(WEIGHT_BITS - 1){1'b1}}};
        end
        else begin
            wadd = s[WEIGHT_BITS-1:0];
        end
    endfunction

    // Unsigned add into a second moment, clamped to all ones.
    function automatic logic [SECOND_W-1:0] sadd(
        input logic [SECOND_W-1:0]  a,
        input logic [CONTRIB_W-1:0] v
    );
        logic [SECOND_W:0] s;
        s = {1'b0, a} + (SECOND_W + 1)'(v);
        sadd = s[SECOND_W] ? {SECOND_W{1'b1}} : s[SECOND_W-1:0];
    endfunction

endpackage

>>> rtl/core/wh2d_cfg.sv
// Configuration register file of the histogram: eight registers written
// through a plain write port, with their reset values.
// Depends on wh2d_pkg.
module wh2d_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wh2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wh2d_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wh2d_pkg::cfg_t                   cfg
);
    import wh2d_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.min_x        <= '0;
            cfg_reg.scale_x      <= SCALE_W'(1024);
            cfg_reg.buckets_x    <= BUCKET_W'(64);
            cfg_reg.min_y        <= '0;
            cfg_reg.scale_y      <= SCALE_W'(1024);
            cfg_reg.buckets_y    <= BUCKET_W'(64);
            cfg_reg.error_mode   <= MODE_NONE;
            cfg_reg.count_enable <= 1'b1;
        end
        else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_X:        cfg_reg.min_x        <= cfg_data[COORD_W-1:0];
                CFG_SCALE_X:      cfg_reg.scale_x      <= cfg_data[SCALE_W-1:0];
                CFG_BUCKETS_X:    cfg_reg.buckets_x    <= cfg_data[BUCKET_W-1:0];
                CFG_MIN_Y:        cfg_reg.min_y        <= cfg_data[COORD_W-1:0];
                CFG_SCALE_Y:      cfg_reg.scale_y      <= cfg_data[SCALE_W-1:0];
                CFG_BUCKETS_Y:    cfg_reg.buckets_y    <= cfg_data[BUCKET_W-1:0];
                CFG_ERROR_MODE:   cfg_reg.error_mode   <= cfg_data[MODE_W-1:0];
                CFG_COUNT_ENABLE: cfg_reg.count_enable <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/wh2d_ctrl.sv
// Controller of the histogram: sequences the clearing pass and the four
// steps of one request, and drives busy and the result strobe.
// Depends on wh2d_pkg.
module wh2d_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output wh2d_pkg::dp_cmd_t   cmd,
    input  wh2d_pkg::dp_stat_t  stat
);
    import wh2d_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_UPD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (stat.clear_last) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_UPD;
            ST_UPD:   state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_UPD);
        end
    end

    always_comb begin
        cmd.clear = (state_reg == ST_CLEAR);
        cmd.load  = (state_reg == ST_IDLE) && start;
        cmd.mul   = (state_reg == ST_MUL);
        cmd.addr  = (state_reg == ST_ADDR);
        cmd.upd   = (state_reg == ST_UPD);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

>>> rtl/core/wh2d_dp.sv
// Datapath of the histogram: binning multipliers, linear bin address,
// bin memory with its read-modify-write, totals and the result register.
// Depends on wh2d_pkg.
module wh2d_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  wh2d_pkg::dp_cmd_t   cmd,
    output wh2d_pkg::dp_stat_t  stat,
    input  wh2d_pkg::cfg_t      cfg,
    input  wh2d_pkg::req_t      request,
    output wh2d_pkg::res_t      result
);
    import wh2d_pkg::*;

    // Bin memory, one word per bin.
    bin_t mem [NBINS];

    req_t                          req_reg;
    logic                          ge_x_reg;
    logic                          ge_y_reg;
    logic [PROD_W-1:0]             prod_x_reg;
    logic [PROD_W-1:0]             prod_y_reg;
    logic [CONTRIB_W-1:0]          contrib_reg;
    logic                          ok_reg;
    logic [LIN_W-1:0]              lin_reg;
    bin_t                          rd_reg;
    res_t                          res_reg;
    logic [LIN_W-1:0]              clr_addr_reg;
    logic signed [WEIGHT_BITS-1:0] wtot_reg;
    logic [SECOND_W-1:0]           stot_reg;

    logic signed [CONTRIB_W-1:0]   sq;
    logic [CONTRIB_W-1:0]          contrib;
    logic [BUCKET_W-1:0]           nx;
    logic [BUCKET_W-1:0]           ny;
    logic [AXIS_W-1:0]             ix;
    logic [AXIS_W-1:0]             iy;
    logic                          ok;
    logic [LIN_W-1:0]              lin;
    logic                          fill;
    bin_t                          upd;
    logic signed [WEIGHT_BITS-1:0] wtot_next;
    logic [SECOND_W-1:0]           stot_next;
    logic                          mem_we;
    logic [LIN_W-1:0]              mem_wa;
    bin_t                          mem_wd;

    // Second moment contribution chosen by the error mode.
    assign sq = CONTRIB_W'(req_reg.sample_value) * CONTRIB_W'(req_reg.sample_value);

    always_comb begin
        unique case (cfg.error_mode)
            MODE_SQUARE:   contrib = sq;
            MODE_VARIANCE: contrib = CONTRIB_W'(req_reg.sample_variance);
            default:       contrib = '0;
        endcase
    end

    // Axis bounds, with counts above the maximum taken as the maximum.
    assign nx = (cfg.buckets_x > BUCKET_W'(MAX_BINS_X)) ? BUCKET_W'(MAX_BINS_X)
                                                        : cfg.buckets_x;
    assign ny = (cfg.buckets_y > BUCKET_W'(MAX_BINS_Y)) ? BUCKET_W'(MAX_BINS_Y)
                                                        : cfg.buckets_y;
    assign ix = prod_x_reg[FRAC_W +: AXIS_W];
    assign iy = prod_y_reg[FRAC_W +: AXIS_W];
    assign ok = ge_x_reg && (ix < AXIS_W'(nx)) && ge_y_reg && (iy < AXIS_W'(ny));
    assign lin = LIN_W'(ix[IDX_X_W-1:0]) + LIN_W'(iy[IDX_Y_W-1:0]) * LIN_W'(nx);

    // Update of the bin that was read, and of the totals.
    assign fill = ok_reg && (req_reg.op == OP_FILL);

    always_comb begin
        upd       = rd_reg;
        wtot_next = wtot_reg;
        stot_next = stot_reg;
        if (fill) begin
            upd.weight = wadd(rd_reg.weight, req_reg.sample_value);
            upd.second = sadd(rd_reg.second, contrib_reg);
            wtot_next  = wadd(wtot_reg, req_reg.sample_value);
            stot_next  = sadd(stot_reg, contrib_reg);
            if (cfg.count_enable && (rd_reg.count != {COUNT_W{1'b1}})) begin
                upd.count = rd_reg.count + COUNT_W'(1);
            end
        end
    end

    assign mem_we = cmd.clear || (cmd.upd && fill);
    assign mem_wa = cmd.clear ? clr_addr_reg : lin_reg;
    assign mem_wd = cmd.clear ? '0 : upd;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.addr) begin
            rd_reg <= mem[lin];
        end
    end

    // Control state: clearing address and the running totals.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clr_addr_reg <= '0;
            wtot_reg     <= '0;
            stot_reg     <= '0;
        end
        else begin
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + LIN_W'(1);
            end
            if (cmd.upd) begin
                wtot_reg <= wtot_next;
                stot_reg <= stot_next;
            end
        end
    end

    // Payload stages.
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            req_reg <= request;
        end
        if (cmd.mul) begin
            ge_x_reg    <= (req_reg.coord_x >= cfg.min_x);
            ge_y_reg    <= (req_reg.coord_y >= cfg.min_y);
            prod_x_reg  <= PROD_W'(req_reg.coord_x - cfg.min_x) * PROD_W'(cfg.scale_x);
            prod_y_reg  <= PROD_W'(req_reg.coord_y - cfg.min_y) * PROD_W'(cfg.scale_y);
            contrib_reg <= contrib;
        end
        if (cmd.addr) begin
            ok_reg  <= ok;
            lin_reg <= ok ? lin : '0;
        end
        if (cmd.upd) begin
            res_reg.accepted     <= ok_reg;
            res_reg.bin_index    <= INDEX_W'(lin_reg);
            res_reg.bin_weight   <= ok_reg ? upd.weight : '0;
            res_reg.bin_second   <= ok_reg ? upd.second : '0;
            res_reg.bin_count    <= ok_reg ? upd.count : '0;
            res_reg.total_weight <= wtot_next;
            res_reg.total_second <= stot_next;
        end
    end

    assign stat.clear_last = (clr_addr_reg == {LIN_W{1'b1}});
    assign result = res_reg;

endmodule

>>> rtl/core/weighted_histogram_2d_fill.sv
// Top level of the two-axis weighted histogram with saturating sums.
// Depends on wh2d_pkg, wh2d_cfg, wh2d_ctrl and wh2d_dp.
//
// Channel         Ports                          Transfer
// request         start, busy, request           taken when start is high and busy is low
// result          done, result                   shown for the one cycle in which done is high
// configuration   cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// A request is handled in steps: it is taken, the two binning products and
// the second-moment contribution are formed, the bin address is built and
// the bin read, and the bin and totals are updated; done then pulses as busy
// falls, so a new request may be taken in the same cycle as the result is shown.
// The pace is set by the read-modify-write of the single bin memory.
// After reset the bin memory is cleared, all 4096 bins at one bin a cycle,
// with busy held high; configuration writes are taken throughout.
// The receiver of results cannot stall the block.
module weighted_histogram_2d_fill (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  wh2d_pkg::req_t                   request,
    output logic                             done,
    output wh2d_pkg::res_t                   result,
    input  logic                             cfg_we,
    input  logic [wh2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wh2d_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wh2d_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Register file: axis limits, scales, bucket counts and modes.
    wh2d_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Controller: clearing pass, then one request at a time.
    wh2d_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Datapath: binning, bin memory and totals; the result register is
    // loaded in the update step, so it is stable while done is high.
    wh2d_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .cfg     (cfg),
        .request (request),
        .result  (result)
    );

endmodule
